// ===== rtl/core/lpr_pkg.sv =====
// Shared types, codes and helper functions of the IPv4 longest-prefix router.
// No dependencies; front, queue, back end, top level and testbench use it by scoped names.
package lpr_pkg;

	// Default depth of the route table (top-level parameter default).
	localparam int unsigned MAX_ROUTES_DEFAULT = 32;
	// Interfaces physically present; a route to an absent interface gives a no-route result.
	localparam int unsigned NUM_INTERFACES = 16;
	// Entries of the queue between front and back end.
	localparam int unsigned QUEUE_DEPTH = 2;
	// Longest meaningful IPv4 prefix.
	localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

	// Input opcodes.
	localparam logic OP_ADD_ROUTE = 1'b0;
	localparam logic OP_ROUTE     = 1'b1;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_FULL     = 3'd1,
		ST_FWD      = 3'd2,
		ST_DROP_TTL = 3'd3,
		ST_NO_ROUTE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		JOB_ADD    = 2'd0,
		JOB_DROP   = 2'd1,
		JOB_LOOKUP = 2'd2
	} job_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_SCAN  = 2'd1,
		BK_REPLY = 2'd2
	} bk_state_t;

	// Classified work item passed from front to back end. The address field holds
	// the route prefix for an add and the destination for a lookup.
	typedef struct packed {
		job_kind_t   kind;
		logic [31:0] addr;
		logic [5:0]  len;
		logic [31:0] hop;
		logic        direct;
		logic [3:0]  port;
		logic [7:0]  ttl;
		logic [15:0] cks;
	} job_t;

	// One row of the route table.
	typedef struct packed {
		logic [31:0] prefix;
		logic [5:0]  len;
		logic [31:0] hop;
		logic        direct;
		logic [3:0]  port;
	} route_t;

	// Network mask for a prefix length of at most 32.
	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = 32'h0;
		end else begin
			m = 32'hFFFF_FFFF << (MAX_PREFIX_LEN - len);
		end
		return m;
	endfunction

	// Incremental header checksum update for a TTL decrement: ~(~old + 0xFEFF),
	// folding the carry back in twice.
	function automatic logic [15:0] ttl_checksum(input logic [15:0] old);
		logic [16:0] sum;
		logic [16:0] fold1;
		logic [16:0] fold2;
		sum   = {1'b0, ~old} + 17'h0FEFF;
		fold1 = {1'b0, sum[15:0]} + {16'h0, sum[16]};
		fold2 = {1'b0, fold1[15:0]} + {16'h0, fold1[16]};
		return ~fold2[15:0];
	endfunction

	function automatic logic port_present(input logic [3:0] port);
		return 32'(port) < NUM_INTERFACES;
	endfunction

endpackage

// ===== rtl/core/lpr_if.sv =====
// Valid/ready channel interfaces for router commands and router results.
// Depends on nothing; the payload fields are plain logic vectors.
interface lpr_cmd_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] net_prefix;
	logic [5:0]  mask_len;
	logic [31:0] gateway_addr;
	logic        has_next_hop;
	logic [3:0]  interface_index;
	logic [31:0] dest_addr;
	logic [7:0]  ttl_in;
	logic [15:0] checksum_in;

	modport source (
		output valid, opcode, net_prefix, mask_len, gateway_addr,
			has_next_hop, interface_index, dest_addr, ttl_in, checksum_in,
		input  ready
	);
	modport sink (
		input  valid, opcode, net_prefix, mask_len, gateway_addr,
			has_next_hop, interface_index, dest_addr, ttl_in, checksum_in,
		output ready
	);
endinterface

interface lpr_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  out_interface;
	logic [31:0] next_hop_out;
	logic [7:0]  ttl_out;
	logic [15:0] checksum_out;

	modport source (
		output valid, status, out_interface, next_hop_out, ttl_out, checksum_out,
		input  ready
	);
	modport sink (
		input  valid, status, out_interface, next_hop_out, ttl_out, checksum_out,
		output ready
	);
endinterface

// ===== rtl/core/lpr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/lpr_front.sv =====
// Front end: takes command words, classifies them and precomputes TTL and checksum.
// Depends on lpr_pkg and lpr_cmd_if.
module lpr_front (
	lpr_cmd_if.sink        cmd,
	input  logic           q_full,
	output logic           q_push,
	output lpr_pkg::job_t  q_job
);

	assign cmd.ready = !q_full;
	assign q_push    = cmd.valid && !q_full;

	always_comb begin
		q_job.addr   = (cmd.opcode == lpr_pkg::OP_ROUTE) ? cmd.dest_addr : cmd.net_prefix;
		q_job.len    = (cmd.mask_len > lpr_pkg::MAX_PREFIX_LEN) ?
			lpr_pkg::MAX_PREFIX_LEN : cmd.mask_len;
		q_job.hop    = cmd.gateway_addr;
		q_job.direct = !cmd.has_next_hop;
		q_job.port   = cmd.interface_index;
		q_job.ttl    = cmd.ttl_in - 8'd1;
		q_job.cks    = lpr_pkg::ttl_checksum(cmd.checksum_in);
		if (cmd.opcode == lpr_pkg::OP_ADD_ROUTE) begin
			q_job.kind = lpr_pkg::JOB_ADD;
		end else if (cmd.ttl_in <= 8'd1) begin
			q_job.kind = lpr_pkg::JOB_DROP;
		end else begin
			q_job.kind = lpr_pkg::JOB_LOOKUP;
		end
	end

endmodule

// ===== rtl/core/lpr_fifo.sv =====
// Short job queue between the router's front and back ends.
// Depends on lpr_pkg for the job type and queue depth.
module lpr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lpr_pkg::job_t  push_job,
	output logic           full,
	input  logic           pop,
	output lpr_pkg::job_t  head_job,
	output logic           empty
);

	localparam int PW = (lpr_pkg::QUEUE_DEPTH > 1) ? $clog2(lpr_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(lpr_pkg::QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(lpr_pkg::QUEUE_DEPTH - 1);

	lpr_pkg::job_t slot_q [lpr_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign full     = (fill_q == CW'(lpr_pkg::QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign head_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/core/lpr_back.sv =====
// Back end: writes routes to the table, scans it for the longest match and
// holds the result word. Depends on lpr_pkg, lpr_res_if and lpr_ram.
module lpr_back #(
	parameter int MAX_ROUTES = lpr_pkg::MAX_ROUTES_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  lpr_pkg::job_t  job,
	output logic           job_pop,
	lpr_res_if.source      res
);

	localparam int AW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
	localparam int CW = $clog2(MAX_ROUTES + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ROUTES);

	lpr_pkg::bk_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          pend_s1;

	logic [31:0] dest_q;
	logic [7:0]  ttl_q;
	logic [15:0] cks_q;

	logic        found_q;
	logic [5:0]  best_len_q;
	logic [3:0]  best_port_q;
	logic [31:0] best_hop_q;
	logic        best_direct_q;

	logic        res_valid_q;
	logic [2:0]  res_status_q;
	logic [3:0]  res_port_q;
	logic [31:0] res_hop_q;
	logic [7:0]  res_ttl_q;
	logic [15:0] res_cks_q;

	logic          res_free;
	logic          res_load;
	logic          scan_start;
	logic          issue;
	logic          ram_we;
	logic          hit;
	logic          take;
	logic [2:0]    nxt_status;
	logic [3:0]    nxt_port;
	logic [31:0]   nxt_hop;
	logic [7:0]    nxt_ttl;
	logic [15:0]   nxt_cks;
	lpr_pkg::route_t wr_route;
	lpr_pkg::route_t rd_route;

	assign res_free = !res_valid_q || res.ready;

	assign wr_route.prefix = job.addr;
	assign wr_route.len    = job.len;
	assign wr_route.hop    = job.hop;
	assign wr_route.direct = job.direct;
	assign wr_route.port   = job.port;

	lpr_ram #(
		.WIDTH ($bits(lpr_pkg::route_t)),
		.DEPTH (MAX_ROUTES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (wr_route),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_route)
	);

	// Match test on the row read out in the previous cycle.
	assign hit  = ((dest_q ^ rd_route.prefix) & lpr_pkg::prefix_mask(rd_route.len)) == 32'h0;
	assign take = pend_s1 && hit && (!found_q || (rd_route.len > best_len_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			lpr_pkg::BK_IDLE: begin
				if (job_valid && job.kind == lpr_pkg::JOB_LOOKUP) begin
					state_d = lpr_pkg::BK_SCAN;
				end
			end
			lpr_pkg::BK_SCAN: begin
				if (idx_q == cnt_q && !pend_s1) begin
					state_d = lpr_pkg::BK_REPLY;
				end
			end
			lpr_pkg::BK_REPLY: begin
				if (res_free) begin
					state_d = lpr_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = lpr_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		job_pop    = 1'b0;
		res_load   = 1'b0;
		scan_start = 1'b0;
		issue      = 1'b0;
		ram_we     = 1'b0;
		nxt_status = lpr_pkg::ST_NO_ROUTE;
		nxt_port   = '0;
		nxt_hop    = '0;
		nxt_ttl    = '0;
		nxt_cks    = '0;
		case (state_q)
			lpr_pkg::BK_IDLE: begin
				if (job_valid) begin
					case (job.kind)
						lpr_pkg::JOB_LOOKUP: begin
							job_pop    = 1'b1;
							scan_start = 1'b1;
						end
						lpr_pkg::JOB_ADD: begin
							job_pop  = res_free;
							res_load = res_free;
							if (cnt_q == FULL_COUNT) begin
								nxt_status = lpr_pkg::ST_FULL;
							end else begin
								nxt_status = lpr_pkg::ST_ADDED;
								ram_we     = res_free;
							end
						end
						default: begin
							job_pop    = res_free;
							res_load   = res_free;
							nxt_status = lpr_pkg::ST_DROP_TTL;
						end
					endcase
				end
			end
			lpr_pkg::BK_SCAN: begin
				issue = (idx_q != cnt_q);
			end
			lpr_pkg::BK_REPLY: begin
				res_load = res_free;
				if (found_q && lpr_pkg::port_present(best_port_q)) begin
					nxt_status = lpr_pkg::ST_FWD;
					nxt_port   = best_port_q;
					nxt_hop    = best_direct_q ? dest_q : best_hop_q;
					nxt_ttl    = ttl_q;
					nxt_cks    = cks_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpr_pkg::BK_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (ram_we) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (scan_start) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_start) begin
			dest_q <= job.addr;
			ttl_q  <= job.ttl;
			cks_q  <= job.cks;
		end
		if (take) begin
			best_len_q    <= rd_route.len;
			best_port_q   <= rd_route.port;
			best_hop_q    <= rd_route.hop;
			best_direct_q <= rd_route.direct;
		end
		if (res_load) begin
			res_status_q <= nxt_status;
			res_port_q   <= nxt_port;
			res_hop_q    <= nxt_hop;
			res_ttl_q    <= nxt_ttl;
			res_cks_q    <= nxt_cks;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.status        = res_status_q;
	assign res.out_interface = res_port_q;
	assign res.next_hop_out  = res_hop_q;
	assign res.ttl_out       = res_ttl_q;
	assign res.checksum_out  = res_cks_q;

`ifndef NO_ASSERTIONS
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_COUNT)
		else $error("route count beyond table depth");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lpr_pkg::BK_SCAN |-> idx_q <= cnt_q)
		else $error("scan index passed route count");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> state_q == lpr_pkg::BK_SCAN)
		else $error("table read outstanding outside a scan");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> cnt_q == $past(cnt_q) + CW'(1))
		else $error("route count moved by other than one");
`endif

endmodule

// ===== rtl/core/ipv4_longest_prefix_router.sv =====
// IPv4 longest-prefix router: route table with add-route and route-datagram words.
// An accepted word goes into the queue; an add or a TTL drop then goes from its head
// into the result register, while a lookup first scans every stored row, one table
// row read per cycle, and then loads its result. Adds and drops pass one per cycle
// while the receiver keeps taking result words; a lookup holds the back end until its result is loaded.
// Reset clears the route count, queue and result valid; table rows are not cleared.
module ipv4_longest_prefix_router #(
	parameter int MAX_ROUTES = lpr_pkg::MAX_ROUTES_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	lpr_cmd_if.sink  cmd,
	lpr_res_if.source res
);

	// The front end classifies each accepted command word: adds go to the table
	// writer, datagrams with a TTL of one or less are marked for dropping, and the
	// rest get their decremented TTL and updated checksum worked out up front.
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	lpr_pkg::job_t q_in;
	lpr_pkg::job_t q_head;

	lpr_front u_front (
		.cmd    (cmd),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (q_in)
	);

	// A short queue decouples the two halves, so the front keeps taking words while
	// the back end is busy scanning the table, until the queue is full.
	lpr_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.head_job (q_head),
		.empty    (q_empty)
	);

	// The back end owns the route table and the result register. Jobs are taken
	// strictly in order, so every lookup sees exactly the routes added before it.
	lpr_back #(
		.MAX_ROUTES (MAX_ROUTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!q_empty),
		.job       (q_head),
		.job_pop   (q_pop),
		.res       (res)
	);

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the IPv4 longest-prefix router: directed and random
// route-add and route-datagram words, checked against an in-bench route table.
// Depends on lpr_pkg, lpr_cmd_if / lpr_res_if and the ipv4_longest_prefix_router top level.
`timescale 1ns / 1ps

module tb_top;

	// Depth of the route table and the receiver/sender idle rate in percent.
	localparam int TABLE_DEPTH = lpr_pkg::MAX_ROUTES_DEFAULT;
	localparam int IDLE_PCT = 15;
	// Settling time before the verdict, with ample margin over a lookup across a full table.
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT = 1_000_000;

	// One command word as the sender sees it.
	typedef struct {
		logic        opcode;
		logic [31:0] prefix;
		logic [5:0]  plen;
		logic [31:0] hop;
		logic        has_hop;
		logic [3:0]  port;
		logic [31:0] dest;
		logic [7:0]  ttl;
		logic [15:0] cks;
	} router_word_t;

	// One result word as the router should give it.
	typedef struct {
		lpr_pkg::status_t status;
		logic [3:0]       port;
		logic [31:0]      hop;
		logic [7:0]       ttl;
		logic [15:0]      cks;
	} route_result_t;

	logic clk;
	logic arst_n;

	lpr_cmd_if cmd_ch ();
	lpr_res_if res_ch ();

	ipv4_longest_prefix_router uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// The bench keeps its own copy of the route table. It is updated at the moment a
	// word is accepted, so every lookup is predicted against exactly the routes that
	// were added before it, which is also the order in which the router handles them.
	logic [31:0] tbl_prefix [TABLE_DEPTH];
	logic [5:0]  tbl_len    [TABLE_DEPTH];
	logic [31:0] tbl_hop    [TABLE_DEPTH];
	logic        tbl_direct [TABLE_DEPTH];
	logic [3:0]  tbl_port   [TABLE_DEPTH];
	int          table_count = 0;

	route_result_t pending_results[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	// Receiver hold-off in cycles, and a flag that switches idling off on both sides.
	int hold_off = 0;
	bit steady_flow = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Network mask for a stored length (already saturated to 32). A shift by the full
	// width gives zero, so a /32 yields all ones.
	function automatic logic [31:0] len_mask(input logic [5:0] len);
		return (len == 6'd0) ? 32'h0 : ~(32'hFFFF_FFFF >> len);
	endfunction

	// Works out the result of one accepted word and applies any table update it makes.
	function automatic route_result_t forward_decision(input router_word_t w);
		route_result_t r;
		logic [31:0] m;
		logic [31:0] sum;
		int best;
		int best_len;
		bit hit;
		r.status = lpr_pkg::ST_ADDED;
		r.port = 4'h0;
		r.hop = 32'h0;
		r.ttl = 8'h0;
		r.cks = 16'h0;
		best = 0;
		best_len = 0;
		hit = 1'b0;
		if (w.opcode == lpr_pkg::OP_ADD_ROUTE) begin
			if (table_count >= TABLE_DEPTH) begin
				r.status = lpr_pkg::ST_FULL;
			end else begin
				tbl_prefix[table_count] = w.prefix;
				tbl_len[table_count] = (w.plen > 6'd32) ? 6'd32 : w.plen;
				tbl_hop[table_count] = w.hop;
				tbl_direct[table_count] = !w.has_hop;
				tbl_port[table_count] = w.port;
				table_count++;
			end
		end else if (w.ttl <= 8'd1) begin
			// Expiring datagrams are dropped before any table access or checksum work.
			r.status = lpr_pkg::ST_DROP_TTL;
		end else begin
			// Strictly longer wins, so among equal lengths the earliest route stays.
			for (int i = 0; i < table_count; i++) begin
				m = len_mask(tbl_len[i]);
				if (((w.dest & m) == (tbl_prefix[i] & m)) && (!hit || tbl_len[i] > best_len)) begin
					hit = 1'b1;
					best = i;
					best_len = tbl_len[i];
				end
			end
			if (!hit || 32'(tbl_port[best]) >= lpr_pkg::NUM_INTERFACES) begin
				r.status = lpr_pkg::ST_NO_ROUTE;
			end else begin
				r.status = lpr_pkg::ST_FWD;
				r.port = tbl_port[best];
				r.hop = tbl_direct[best] ? w.dest : tbl_hop[best];
				r.ttl = w.ttl - 8'd1;
				// One's complement update for the TTL byte dropping by one, with the
				// carry folded back in twice.
				sum = {16'h0, ~w.cks} + 32'h0000_FEFF;
				sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
				sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
				r.cks = ~sum[15:0];
			end
		end
		return r;
	endfunction

	// Fields that the chosen operation ignores still carry random values.
	function automatic router_word_t noise_word();
		router_word_t w;
		w.opcode = 1'($urandom);
		w.prefix = $urandom;
		w.plen = 6'($urandom);
		w.hop = $urandom;
		w.has_hop = 1'($urandom);
		w.port = 4'($urandom);
		w.dest = $urandom;
		w.ttl = 8'($urandom);
		w.cks = 16'($urandom);
		return w;
	endfunction

	function automatic router_word_t add_word(input logic [31:0] prefix, input logic [5:0] plen,
			input logic [31:0] hop, input logic has_hop, input logic [3:0] port);
		router_word_t w;
		w = noise_word();
		w.opcode = lpr_pkg::OP_ADD_ROUTE;
		w.prefix = prefix;
		w.plen = plen;
		w.hop = hop;
		w.has_hop = has_hop;
		w.port = port;
		return w;
	endfunction

	function automatic router_word_t lookup_word(input logic [31:0] dest, input logic [7:0] ttl,
			input logic [15:0] cks);
		router_word_t w;
		w = noise_word();
		w.opcode = lpr_pkg::OP_ROUTE;
		w.dest = dest;
		w.ttl = ttl;
		w.cks = cks;
		return w;
	endfunction

	// Most destinations fall inside a stored route so that the longest-match logic is
	// exercised; the rest are random and mostly miss until a default route exists.
	function automatic router_word_t random_lookup();
		logic [31:0] dest;
		logic [31:0] m;
		logic [7:0] ttl;
		logic [15:0] cks;
		int pick;
		dest = $urandom;
		if (table_count > 0 && $urandom_range(0, 99) < 65) begin
			pick = $urandom_range(0, table_count - 1);
			m = len_mask(tbl_len[pick]);
			dest = (tbl_prefix[pick] & m) | (dest & ~m);
		end
		if ($urandom_range(0, 99) < 8) begin
			ttl = 8'($urandom_range(0, 1));
		end else begin
			ttl = 8'($urandom_range(2, 255));
		end
		case ($urandom_range(0, 19))
			0: begin
				cks = 16'h0000;
			end
			1: begin
				cks = 16'hFFFF;
			end
			default: begin
				cks = 16'($urandom);
			end
		endcase
		return lookup_word(dest, ttl, cks);
	endfunction

	// Routes nested under or equal to existing ones give competing matches and ties;
	// lengths above 32 check saturation.
	function automatic router_word_t random_add(input bit allow_default);
		logic [31:0] prefix;
		logic [31:0] m;
		logic [31:0] hop;
		logic [5:0] plen;
		int pick;
		int roll;
		prefix = $urandom;
		roll = $urandom_range(0, 99);
		if (allow_default && roll < 5) begin
			plen = 6'd0;
		end else if (table_count > 0 && roll < 35) begin
			pick = $urandom_range(0, table_count - 1);
			m = len_mask(tbl_len[pick]);
			prefix = (tbl_prefix[pick] & m) | (prefix & ~m);
			plen = tbl_len[pick] + 6'($urandom_range(0, 8));
		end else if (roll < 45) begin
			plen = 6'($urandom_range(33, 63));
		end else if (roll < 50) begin
			plen = 6'($urandom_range(1, 7));
		end else begin
			plen = 6'($urandom_range(8, 32));
		end
		case ($urandom_range(0, 9))
			0: begin
				hop = 32'h0;
			end
			1: begin
				hop = 32'hFFFF_FFFF;
			end
			default: begin
				hop = $urandom;
			end
		endcase
		return add_word(prefix, plen, hop, 1'($urandom), 4'($urandom_range(0, 15)));
	endfunction

	// Offers one word and returns in the time step in which it was accepted. Valid is
	// left high, so the caller either offers the next word at once or lowers it.
	task automatic send_word(input router_word_t w);
		int gap;
		gap = 0;
		if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
			gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= w.opcode;
		cmd_ch.net_prefix <= w.prefix;
		cmd_ch.mask_len <= w.plen;
		cmd_ch.gateway_addr <= w.hop;
		cmd_ch.has_next_hop <= w.has_hop;
		cmd_ch.interface_index <= w.port;
		cmd_ch.dest_addr <= w.dest;
		cmd_ch.ttl_in <= w.ttl;
		cmd_ch.checksum_in <= w.cks;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		pending_results.insert(pending_results.size(), forward_decision(w));
	endtask

	// The sender goes quiet until every predicted result word has come back.
	task automatic wait_results_drained();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch at %0d ns: %s expected 0x%0h, got 0x%0h",
				$time, what, exp_v, act_v);
		end
	endtask

	// Empty table: every datagram with a live TTL has no route; TTLs of 0 and 1 drop.
	task automatic test_empty_table();
		send_word(lookup_word(32'h0A01_0203, 8'd64, 16'h1234));
		send_word(lookup_word(32'hFFFF_FFFF, 8'd0, 16'hFFFF));
		send_word(lookup_word(32'h0000_0000, 8'd1, 16'h0000));
		send_word(lookup_word(32'h8000_0001, 8'd255, 16'hFFFF));
		wait_results_drained();
	endtask

	// Hand-built table: nested prefixes, a tie between two /16 routes where the first
	// (a direct route) must win, saturated lengths, and next hops at both extremes.
	task automatic test_directed_routes();
		send_word(add_word(32'h0A00_0000, 6'd8, 32'hFFFF_FFFF, 1'b1, 4'd1));
		send_word(add_word(32'h0A01_0000, 6'd16, 32'hDEAD_BEEF, 1'b0, 4'd2));
		send_word(add_word(32'h0A01_0203, 6'd32, 32'h0000_0000, 1'b1, 4'd15));
		send_word(add_word(32'h0A01_0000, 6'd16, 32'h0A0A_0A0A, 1'b1, 4'd3));
		send_word(add_word(32'hFFFF_FFFF, 6'd33, 32'h1234_5678, 1'b0, 4'd0));
		send_word(add_word(32'hC0A8_0000, 6'd63, 32'hC0A8_00FE, 1'b1, 4'd14));
		send_word(lookup_word(32'h0A01_0203, 8'd2, 16'hFFFF));
		send_word(lookup_word(32'h0A01_0909, 8'd255, 16'h0000));
		send_word(lookup_word(32'h0AC8_0001, 8'd128, 16'h5A5A));
		send_word(lookup_word(32'hFFFF_FFFF, 8'd255, 16'h0000));
		send_word(lookup_word(32'hC0A8_0000, 8'd2, 16'hFFFF));
		send_word(lookup_word(32'hC0A8_0001, 8'd64, 16'h1234));
		send_word(lookup_word(32'h0B00_0000, 8'd64, 16'h1234));
		send_word(lookup_word(32'h0A01_0203, 8'd1, 16'h4321));
		wait_results_drained();
	endtask

	// The table grows slowly under random lookups, stopping short of full so that the
	// default route and the full-table behaviour can be tested on their own later.
	task automatic test_table_growth();
		for (int n = 0; n < 600; n++) begin
			if (table_count < TABLE_DEPTH - 6 && $urandom_range(0, 99) < 5) begin
				send_word(random_add(1'b0));
			end else begin
				send_word(random_lookup());
			end
		end
		wait_results_drained();
	endtask

	// The receiver holds off for a long stretch while lookups keep coming, so the
	// router's queue fills and its input stalls; everything must drain in order.
	task automatic test_output_backpressure();
		hold_off <= 300;
		for (int n = 0; n < 60; n++) begin
			send_word(random_lookup());
		end
		wait_results_drained();
	endtask

	// A /0 route matches every destination but loses to any longer match.
	task automatic test_default_route();
		send_word(add_word($urandom, 6'd0, $urandom, 1'($urandom), 4'($urandom)));
		for (int n = 0; n < 100; n++) begin
			send_word(random_lookup());
		end
		wait_results_drained();
	endtask

	// Fill the table, then keep adding: each further add reports a full table.
	task automatic test_table_full();
		while (table_count < TABLE_DEPTH) begin
			send_word(random_add(1'b1));
			send_word(random_lookup());
		end
		for (int n = 0; n < 12; n++) begin
			send_word(random_add(1'b1));
			send_word(random_lookup());
		end
		wait_results_drained();
	endtask

	// A long stretch with no idling on either side.
	task automatic test_steady_flow();
		steady_flow = 1'b1;
		for (int n = 0; n < 400; n++) begin
			if ($urandom_range(0, 99) < 15) begin
				send_word(random_add(1'b1));
			end else begin
				send_word(random_lookup());
			end
		end
		wait_results_drained();
		steady_flow = 1'b0;
	endtask

	task automatic test_random_mix();
		for (int n = 0; n < 660; n++) begin
			if ($urandom_range(0, 99) < 12) begin
				send_word(random_add(1'b1));
			end else begin
				send_word(random_lookup());
			end
		end
		wait_results_drained();
	endtask

	// Receiver: ready drops at random, or for a requested hold-off counted here.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				res_ch.ready <= 1'b0;
				hold_off <= hold_off - 1;
			end else begin
				res_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Every accepted result word is checked field by field against the oldest
	// prediction. Sampling at the edge sees the values from before that edge, as the
	// router does.
	always @(posedge clk) begin
		route_result_t exp_r;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				note_mismatch("result word with nothing expected, status", 32'h0,
					32'(res_ch.status));
			end else begin
				exp_r = pending_results.pop_front();
				if (res_ch.status !== exp_r.status) begin
					note_mismatch("status", 32'(exp_r.status), 32'(res_ch.status));
				end
				if (res_ch.out_interface !== exp_r.port) begin
					note_mismatch("out_interface", 32'(exp_r.port), 32'(res_ch.out_interface));
				end
				if (res_ch.next_hop_out !== exp_r.hop) begin
					note_mismatch("next_hop_out", exp_r.hop, res_ch.next_hop_out);
				end
				if (res_ch.ttl_out !== exp_r.ttl) begin
					note_mismatch("ttl_out", 32'(exp_r.ttl), 32'(res_ch.ttl_out));
				end
				if (res_ch.checksum_out !== exp_r.cks) begin
					note_mismatch("checksum_out", 32'(exp_r.cks), 32'(res_ch.checksum_out));
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.opcode <= lpr_pkg::OP_ADD_ROUTE;
		cmd_ch.net_prefix <= '0;
		cmd_ch.mask_len <= '0;
		cmd_ch.gateway_addr <= '0;
		cmd_ch.has_next_hop <= 1'b0;
		cmd_ch.interface_index <= '0;
		cmd_ch.dest_addr <= '0;
		cmd_ch.ttl_in <= '0;
		cmd_ch.checksum_in <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_directed_routes();
		test_table_growth();
		test_output_backpressure();
		test_default_route();
		test_table_full();
		test_steady_flow();
		test_random_mix();

		// Let any stray word surface before the verdict.
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/lpr_pkg.sv
rtl/core/lpr_if.sv
rtl/core/lpr_ram.sv
rtl/core/lpr_front.sv
rtl/core/lpr_fifo.sv
rtl/core/lpr_back.sv
rtl/core/ipv4_longest_prefix_router.sv
dv/tb_top.sv
